@@ rtl/opt_pkg.sv @@
// ----------------------------------------------------------------------------
// opt_pkg: shared types and constants for the ordered process table
// Item layouts, operation codes and the links that pass along the slot row.
// ----------------------------------------------------------------------------
package opt_pkg;

   localparam int CAPACITY = 16;
   localparam int ID_W     = 22;

   localparam logic [1:0] KIND_INSERT = 2'd0;
   localparam logic [1:0] KIND_DELETE = 2'd1;
   localparam logic [1:0] KIND_SET    = 2'd2;
   localparam logic [1:0] KIND_QUERY  = 2'd3;

   typedef struct packed {
      logic [1:0]      kind;
      logic [ID_W-1:0] proc_id;
      logic            active_in;
   } req_type;

   typedef struct packed {
      logic            status;
      logic            found;
      logic            active_out;
      logic            head_valid;
      logic [ID_W-1:0] head_id;
   } rsp_type;

   // Broadcast to every slot
   typedef struct packed {
      logic            cmp_en;
      logic            apply_en;
      logic [1:0]      kind;
      logic [ID_W-1:0] proc_id;
      logic            active_in;
   } cmd_type;

   // Passed from older slot to younger slot
   typedef struct packed {
      logic hit_seen;
      logic vld;
   } fwd_link_type;

   // Contents of a slot, passed from younger slot to older slot
   typedef struct packed {
      logic            vld;
      logic [ID_W-1:0] id;
      logic            act;
   } back_link_type;

   typedef struct packed {
      logic            found;
      logic            full;
      logic            match_act;
      logic            head_vld;
      logic [ID_W-1:0] head_id;
   } chain_stat_type;

endpackage

@@ rtl/opt_slot.sv @@
// ----------------------------------------------------------------------------
// opt_slot: one entry of the process table
// Holds an id, a flag and a valid bit; compares, appends, shifts and updates.
// ----------------------------------------------------------------------------
module opt_slot (
   input  logic                  clock,
   input  logic                  reset,
   input  opt_pkg::cmd_type       cmd,
   input  opt_pkg::fwd_link_type  fwd_from_prev,
   input  opt_pkg::back_link_type back_from_next,
   output opt_pkg::fwd_link_type  fwd_to_next,
   output opt_pkg::back_link_type back_to_prev,
   output logic                  first_act
);
   import opt_pkg::*;

   logic            vld_ff, vld_in;
   logic [ID_W-1:0] id_ff, id_in;
   logic            act_ff, act_in;
   logic            hit_ff, hit_in;
   logic            first;

   // oldest match: hit here and none in an older slot
   assign first = hit_ff & ~fwd_from_prev.hit_seen;

   assign fwd_to_next.hit_seen = fwd_from_prev.hit_seen | hit_ff;
   assign fwd_to_next.vld      = vld_ff;
   assign back_to_prev.vld     = vld_ff;
   assign back_to_prev.id      = id_ff;
   assign back_to_prev.act     = act_ff;
   assign first_act            = first & act_ff;

   always_comb begin
      vld_in = vld_ff;
      id_in  = id_ff;
      act_in = act_ff;
      hit_in = hit_ff;
      if (cmd.cmp_en) begin
         hit_in = vld_ff && (id_ff == cmd.proc_id);
      end
      if (cmd.apply_en) begin
         case (cmd.kind)
            KIND_INSERT: begin
               // tail slot: empty with a filled older neighbour
               if (!vld_ff && fwd_from_prev.vld) begin
                  vld_in = 1'b1;
                  id_in  = cmd.proc_id;
                  act_in = cmd.active_in;
               end
            end
            KIND_DELETE: begin
               // close the gap: everything from the match onwards moves up
               if (fwd_to_next.hit_seen) begin
                  vld_in = back_from_next.vld;
                  id_in  = back_from_next.id;
                  act_in = back_from_next.act;
               end
            end
            KIND_SET: begin
               if (first) begin
                  act_in = cmd.active_in;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
         hit_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
         hit_ff <= hit_in;
      end
      id_ff  <= id_in;
      act_ff <= act_in;
   end

endmodule

@@ rtl/opt_chain.sv @@
// ----------------------------------------------------------------------------
// opt_chain: the row of table slots
// Oldest entry sits in slot 0; links run both ways between neighbours.
// ----------------------------------------------------------------------------
module opt_chain (
   input  logic                   clock,
   input  logic                   reset,
   input  opt_pkg::cmd_type        cmd,
   output opt_pkg::chain_stat_type stat
);
   import opt_pkg::*;

   fwd_link_type  fwd  [CAPACITY+1];
   back_link_type back [CAPACITY+1];
   logic [CAPACITY-1:0] first_act;

   assign fwd[0].hit_seen = 1'b0;
   assign fwd[0].vld      = 1'b1;
   assign back[CAPACITY]  = '0;

   for (genvar g = 0; g < CAPACITY; g++) begin : g_slot
      opt_slot u_slot (
         .clock          (clock),
         .reset          (reset),
         .cmd            (cmd),
         .fwd_from_prev  (fwd[g]),
         .back_from_next (back[g+1]),
         .fwd_to_next    (fwd[g+1]),
         .back_to_prev   (back[g]),
         .first_act      (first_act[g])
      );
   end

   assign stat.found     = fwd[CAPACITY].hit_seen;
   assign stat.full      = fwd[CAPACITY].vld;
   assign stat.match_act = |first_act;
   assign stat.head_vld  = back[0].vld;
   assign stat.head_id   = back[0].vld ? back[0].id : '0;

endmodule

@@ rtl/ordered_process_table.sv @@
// ----------------------------------------------------------------------------
// ordered_process_table: insertion-ordered table of process entries
// Insert, delete, set-state and query on up to CAPACITY entries.
// ----------------------------------------------------------------------------
// Each request passes through the accept edge, a compare state in which every
// slot compares its id with the request, and an apply state in which the oldest
// match is picked along the slot row and the table is updated (append at the
// tail, shift-up on delete, flag rewrite on set). Only one request is taken
// at a time; the result sits in an output register, so the next request is
// accepted while it waits, and the update of that next request holds until
// the register is free. The head fields of a result show the table as it
// stands after that request.
module ordered_process_table (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  opt_pkg::req_type  req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output opt_pkg::rsp_type  rsp_data
);
   import opt_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_CMP   = 2'd1;
   localparam logic [1:0] ST_APPLY = 2'd2;

   logic [1:0]     state_ff, state_in;
   req_type        req_ff, req_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           status_ff, status_in;
   logic           found_ff, found_in;
   logic           act_ff, act_in;
   logic           go;
   cmd_type        cmd;
   chain_stat_type stat;

   assign req_ready = (state_ff == ST_IDLE);
   assign go        = (state_ff == ST_APPLY) && (!rsp_valid_ff || rsp_ready);

   assign cmd.cmp_en    = (state_ff == ST_CMP);
   assign cmd.apply_en  = go;
   assign cmd.kind      = req_ff.kind;
   assign cmd.proc_id   = req_ff.proc_id;
   assign cmd.active_in = req_ff.active_in;

   opt_chain u_chain (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .stat  (stat)
   );

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      rsp_valid_in = rsp_valid_ff;
      status_in    = status_ff;
      found_in     = found_ff;
      act_in       = act_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            state_in = ST_APPLY;
         end
         ST_APPLY: begin
            if (go) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               if (req_ff.kind == KIND_INSERT) begin
                  status_in = stat.full;
                  found_in  = 1'b0;
                  act_in    = 1'b0;
               end else begin
                  status_in = ~stat.found;
                  found_in  = stat.found;
                  if (req_ff.kind == KIND_SET) begin
                     act_in = stat.found & req_ff.active_in;
                  end else begin
                     act_in = stat.match_act;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff    <= req_in;
      status_ff <= status_in;
      found_ff  <= found_in;
      act_ff    <= act_in;
   end

   // head is taken live from slot 0: the table holds still until the next
   // update, which waits for this item to leave
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_data.status     = status_ff;
   assign rsp_data.found      = found_ff;
   assign rsp_data.active_out = act_ff;
   assign rsp_data.head_valid = stat.head_vld;
   assign rsp_data.head_id    = stat.head_id;

   a_apply_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      go |=> rsp_valid_ff)
      else $error("update done without a result");

   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && found_ff |-> !status_ff)
      else $error("match reported with failure status");

   a_empty_not_full: assert property (@(posedge clock) disable iff (reset)
      !stat.head_vld |-> !stat.full)
      else $error("empty table reads as full");

   a_table_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && $past(rsp_valid_ff) && !$past(rsp_ready)
      |-> $stable(stat.head_id))
      else $error("head changed under a waiting result");

endmodule

@@ bench/ordered_process_table_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_process_table_tb: self-checking bench for the ordered process table
// A short table of directed items covers the empty and full table, the
// extreme ids, duplicates and every operation. Random items follow, checked
// against a software copy of the table, with gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module ordered_process_table_tb;
   import opt_pkg::*;

   localparam int N_RANDOM = 1075;

   typedef struct {
      req_type req;
      bit      literal;
      rsp_type want;
   } dir_row_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // Software copy of the table
   logic [ID_W-1:0] tbl_ids [CAPACITY];
   logic            tbl_act [CAPACITY];
   int              tbl_count;

   rsp_type     pending_rsp[$];
   dir_row_type dir_rows[$];
   int          n_errors;
   int          req_calm_left;
   bit          req_calm;

   ordered_process_table u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      #5_000_000;
      $display("ordered_process_table_tb: FAIL");
      $finish;
   end

   // Mostly short, now and then long
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) begin
         return $urandom_range(1, 3);
      end else if (roll < 95) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 50);
   endfunction

   function automatic rsp_type table_result(req_type r);
      rsp_type o;
      int      pos;
      o        = '0;
      o.status = 1'b1;
      pos      = -1;
      if (r.kind == KIND_INSERT) begin
         if (tbl_count < CAPACITY) begin
            tbl_ids[tbl_count] = r.proc_id;
            tbl_act[tbl_count] = r.active_in;
            tbl_count++;
            o.status = 1'b0;
         end
      end else begin
         for (int i = 0; i < tbl_count; i++) begin
            if (pos < 0 && tbl_ids[i] == r.proc_id) pos = i;
         end
         if (pos >= 0) begin
            o.status = 1'b0;
            o.found  = 1'b1;
            case (r.kind)
               KIND_DELETE: begin
                  o.active_out = tbl_act[pos];
                  // close the gap, keep the order of the rest
                  for (int i = pos; i + 1 < tbl_count; i++) begin
                     tbl_ids[i] = tbl_ids[i + 1];
                     tbl_act[i] = tbl_act[i + 1];
                  end
                  tbl_count--;
               end
               KIND_SET: begin
                  tbl_act[pos] = r.active_in;
                  o.active_out = r.active_in;
               end
               default: begin
                  o.active_out = tbl_act[pos];
               end
            endcase
         end
      end
      o.head_valid = (tbl_count > 0);
      o.head_id    = (tbl_count > 0) ? tbl_ids[0] : '0;
      return o;
   endfunction

   function automatic void compare_field(string name, logic [ID_W-1:0] want,
                                         logic [ID_W-1:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %h, actual %h", name, want, got);
         n_errors++;
      end
   endfunction

   task automatic add_row(logic [1:0] kind, logic [ID_W-1:0] id, logic act,
                          bit literal, rsp_type want);
      dir_row_type row;
      row.req     = '{kind, id, act};
      row.literal = literal;
      row.want    = want;
      dir_rows.push_back(row);
   endtask

   task automatic send_item(req_type r, bit literal, rsp_type want);
      int      gap;
      rsp_type predicted;
      gap = 0;
      if (req_calm_left == 0) begin
         req_calm      = ($urandom_range(0, 3) == 0);
         req_calm_left = $urandom_range(20, 120);
      end
      req_calm_left--;
      if (!req_calm && $urandom_range(0, 1) == 1) gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = table_result(r);
      pending_rsp.push_back(literal ? want : predicted);
   endtask

   // Result side: check each item taken, then pick the next ready
   initial begin
      rsp_type want;
      int      stall_left;
      int      calm_left;
      bit      calm;
      stall_left = 0;
      calm_left  = 0;
      calm       = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            if (pending_rsp.size() == 0) begin
               $error("result with no request outstanding: %p", rsp_data);
               n_errors++;
            end else begin
               want = pending_rsp.pop_front();
               compare_field("status", ID_W'(want.status), ID_W'(rsp_data.status));
               compare_field("found", ID_W'(want.found), ID_W'(rsp_data.found));
               compare_field("active_out", ID_W'(want.active_out),
                             ID_W'(rsp_data.active_out));
               compare_field("head_valid", ID_W'(want.head_valid),
                             ID_W'(rsp_data.head_valid));
               compare_field("head_id", want.head_id, rsp_data.head_id);
            end
         end
         if (calm_left == 0) begin
            calm      = ($urandom_range(0, 3) == 0);
            calm_left = $urandom_range(100, 400);
         end
         calm_left--;
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (!calm && $urandom_range(0, 99) < 25) stall_left = pick_gap();
         end
      end
   end

   initial begin
      logic [ID_W-1:0] id_pool [8];
      req_type         r;
      int              insert_pct;
      int              roll;
      n_errors      = 0;
      tbl_count     = 0;
      req_calm_left = 0;
      req_calm      = 1'b0;
      insert_pct    = 50;

      // empty table, extreme ids, duplicates, every operation, then full
      add_row(KIND_QUERY,  22'h000000, 1'b1, 1, '{1'b1, 1'b0, 1'b0, 1'b0, 22'h0});
      add_row(KIND_DELETE, 22'h000005, 1'b0, 1, '{1'b1, 1'b0, 1'b0, 1'b0, 22'h0});
      add_row(KIND_SET,    22'h000005, 1'b1, 1, '{1'b1, 1'b0, 1'b0, 1'b0, 22'h0});
      add_row(KIND_INSERT, 22'h3FFFFF, 1'b1, 1,
              '{1'b0, 1'b0, 1'b0, 1'b1, 22'h3FFFFF});
      add_row(KIND_INSERT, 22'h000000, 1'b0, 0, '0);
      add_row(KIND_INSERT, 22'h3FFFFF, 1'b0, 0, '0);
      add_row(KIND_QUERY,  22'h3FFFFF, 1'b0, 0, '0);
      add_row(KIND_SET,    22'h3FFFFF, 1'b0, 0, '0);
      add_row(KIND_DELETE, 22'h3FFFFF, 1'b1, 0, '0);
      add_row(KIND_QUERY,  22'h3FFFFF, 1'b1, 0, '0);
      for (int k = 0; k < CAPACITY - 2; k++) begin
         add_row(KIND_INSERT, {k[3:0], 18'h2AAAA ^ {18{k[0]}}}, k[0], 0, '0);
      end
      add_row(KIND_INSERT, 22'h155555, 1'b1, 1, '{1'b1, 1'b0, 1'b0, 1'b1, 22'h0});

      while (reset) @(posedge clock);
      foreach (dir_rows[i]) send_item(dir_rows[i].req, dir_rows[i].literal,
                                      dir_rows[i].want);

      id_pool[0] = 22'h000000;
      id_pool[1] = 22'h3FFFFF;
      for (int k = 2; k < 8; k++) id_pool[k] = ID_W'($urandom());
      for (int n = 0; n < N_RANDOM; n++) begin
         // swing the fill level between nearly empty and full
         if (n % 60 == 0) begin
            case ($urandom_range(0, 4))
               0: insert_pct = 15;
               1: insert_pct = 35;
               2: insert_pct = 50;
               3: insert_pct = 65;
               default: insert_pct = 85;
            endcase
         end
         if (n % 150 == 149) id_pool[3'($urandom_range(2, 7))] = ID_W'($urandom());
         roll = $urandom_range(0, 99);
         if (roll < insert_pct) begin
            r.kind = KIND_INSERT;
         end else begin
            case ($urandom_range(0, 2))
               0: r.kind = KIND_DELETE;
               1: r.kind = KIND_SET;
               default: r.kind = KIND_QUERY;
            endcase
         end
         if ($urandom_range(0, 99) < 85) begin
            r.proc_id = id_pool[3'($urandom_range(0, 7))];
         end else begin
            r.proc_id = ID_W'($urandom());
         end
         r.active_in = 1'($urandom_range(0, 1));
         send_item(r, 1'b0, '0);
      end
      req_valid <= 1'b0;

      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (n_errors == 0) begin
         $display("ordered_process_table_tb: PASS");
      end else begin
         $display("ordered_process_table_tb: FAIL");
      end
      $finish;
   end

endmodule
